@@ rtl/core/hsfc_pkg.sv @@
// Shared types and constants for the half/single precision converter.
`default_nettype none

package hsfc_pkg;

  localparam logic [31:0] SINGLE_INF_BITS    = 32'h7F80_0000;
  localparam logic [15:0] HALF_INF_BITS      = 16'h7C00;
  localparam logic [15:0] HALF_QNAN_BIT      = 16'h0200;
  localparam logic [7:0]  EXP_REBIAS         = 8'd112;
  localparam logic [7:0]  SINGLE_EXP_MAX     = 8'hFF;
  localparam logic [7:0]  NARROW_OVF_EXP     = 8'd142;
  localparam logic [7:0]  NARROW_TINY_EXP    = 8'd102;
  localparam logic [7:0]  NARROW_NORM_EXP    = 8'd113;
  localparam logic [7:0]  NARROW_SUB_SHIFT   = 8'd126;
  localparam logic [7:0]  WIDEN_SUB_EXP_BASE = 8'd103;
  localparam logic [4:0]  HALF_EXP_MAX       = 5'd31;
  localparam logic [4:0]  HALF_EXP_TOP       = 5'd30;

  // How the last stage builds the result of an item.
  typedef enum logic [1:0] {
    KIND_DIRECT      = 2'd0,
    KIND_WIDEN_SUB   = 2'd1,
    KIND_NARROW_SUB  = 2'd2,
    KIND_NARROW_NORM = 2'd3
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        sign;
    logic [31:0] direct;
    logic [7:0]  exp;
    logic [4:0]  shamt;
    logic [23:0] mant;
  } stage_a_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        sign;
    logic [31:0] direct;
    logic [7:0]  exp;
    logic [9:0]  frac;
    logic        up;
  } stage_b_t;

endpackage

`default_nettype wire

@@ rtl/core/hsfc_classify.sv @@
// First stage: classifies the operand and settles specials, zeros, overflow and plain widening.
`default_nettype none

module hsfc_classify (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              mode,
  input  wire logic [31:0]       operand_bits,
  output hsfc_pkg::stage_a_t     stage_a
);
  import hsfc_pkg::*;

  stage_a_t    stage_a_next;
  logic [4:0]  hexp;
  logic [9:0]  hmant;
  logic [3:0]  top_bit;
  logic [7:0]  bexp;
  logic [22:0] smant;
  logic [15:0] half_special;

  assign hexp  = operand_bits[14:10];
  assign hmant = operand_bits[9:0];
  assign bexp  = operand_bits[30:23];
  assign smant = operand_bits[22:0];

  // Position of the highest set bit of a half subnormal mantissa.
  always_comb begin
    top_bit = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (hmant[i]) begin
        top_bit = 4'(i);
      end
    end
  end

  always_comb begin
    half_special = {operand_bits[31], 15'b0} | HALF_INF_BITS;
    if (smant != 23'b0) begin
      half_special = half_special | HALF_QNAN_BIT | {6'b0, smant[22:13]};
    end
  end

  always_comb begin
    stage_a_next        = '0;
    stage_a_next.valid  = in_valid;
    stage_a_next.kind   = KIND_DIRECT;
    if (!mode) begin
      stage_a_next.sign = operand_bits[15];
      if (hexp == 5'd0) begin
        if (hmant == 10'd0) begin
          stage_a_next.direct = {operand_bits[15], 31'b0};
        end else begin
          stage_a_next.kind  = KIND_WIDEN_SUB;
          stage_a_next.exp   = WIDEN_SUB_EXP_BASE + {4'b0, top_bit};
          stage_a_next.shamt = 5'd10 - {1'b0, top_bit};
          stage_a_next.mant  = {14'b0, hmant};
        end
      end else if (hexp == HALF_EXP_MAX) begin
        stage_a_next.direct = {operand_bits[15], 31'b0} | SINGLE_INF_BITS |
                              {9'b0, hmant, 13'b0};
      end else begin
        stage_a_next.direct = {operand_bits[15], {3'b0, hexp} + EXP_REBIAS, hmant, 13'b0};
      end
    end else begin
      stage_a_next.sign = operand_bits[31];
      if (bexp == SINGLE_EXP_MAX) begin
        stage_a_next.direct = {16'b0, half_special};
      end else if (bexp > NARROW_OVF_EXP) begin
        stage_a_next.direct = {16'b0, {operand_bits[31], 15'b0} | HALF_INF_BITS};
      end else if (bexp < NARROW_TINY_EXP) begin
        stage_a_next.direct = {16'b0, operand_bits[31], 15'b0};
      end else if (bexp < NARROW_NORM_EXP) begin
        stage_a_next.kind  = KIND_NARROW_SUB;
        stage_a_next.shamt = 5'(NARROW_SUB_SHIFT - bexp);
        stage_a_next.mant  = {1'b1, smant};
      end else begin
        stage_a_next.kind = KIND_NARROW_NORM;
        stage_a_next.exp  = bexp - EXP_REBIAS;
        stage_a_next.mant = {1'b0, smant};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_a <= '0;
    end else begin
      stage_a <= stage_a_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hsfc_align.sv @@
// Second stage: normalizing shift for widening and the round decision for narrowing.
`default_nettype none

module hsfc_align (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hsfc_pkg::stage_a_t stage_a,
  output hsfc_pkg::stage_b_t     stage_b
);
  import hsfc_pkg::*;

  stage_b_t    stage_b_next;
  logic [23:0] quot;
  logic [23:0] mask;
  logic [23:0] rem;
  logic [23:0] half;

  // Subnormal narrowing splits the mantissa at the shift point into kept and dropped bits.
  assign quot = stage_a.mant >> stage_a.shamt;
  assign mask = 24'((25'd1 << stage_a.shamt) - 25'd1);
  assign rem  = stage_a.mant & mask;
  assign half = 24'(25'd1 << (stage_a.shamt - 5'd1));

  always_comb begin
    stage_b_next        = '0;
    stage_b_next.valid  = stage_a.valid;
    stage_b_next.kind   = stage_a.kind;
    stage_b_next.sign   = stage_a.sign;
    stage_b_next.direct = stage_a.direct;
    stage_b_next.exp    = stage_a.exp;
    unique case (stage_a.kind)
      KIND_WIDEN_SUB: begin
        stage_b_next.frac = 10'(stage_a.mant[9:0] << stage_a.shamt);
      end
      KIND_NARROW_SUB: begin
        stage_b_next.frac = quot[9:0];
        stage_b_next.up   = (rem > half) || ((rem == half) && quot[0]);
      end
      KIND_NARROW_NORM: begin
        stage_b_next.frac = stage_a.mant[22:13];
        stage_b_next.up   = stage_a.mant[12] &&
                            ((stage_a.mant[11:0] != 12'd0) || stage_a.mant[13]);
      end
      default: begin
        stage_b_next.frac = 10'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_b <= '0;
    end else begin
      stage_b <= stage_b_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/hsfc_pack.sv @@
// Third stage: applies the rounding increment and packs the result word.
`default_nettype none

module hsfc_pack (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hsfc_pkg::stage_b_t stage_b,
  output logic                   done,
  output logic [31:0]            result_bits
);
  import hsfc_pkg::*;

  logic [10:0] sum;
  logic [31:0] result_next;
  logic [4:0]  hexp;

  assign sum  = {1'b0, stage_b.frac} + {10'b0, stage_b.up};
  assign hexp = stage_b.exp[4:0];

  always_comb begin
    unique case (stage_b.kind)
      KIND_WIDEN_SUB: begin
        result_next = {stage_b.sign, stage_b.exp, stage_b.frac, 13'b0};
      end
      KIND_NARROW_SUB: begin
        // A carry into bit 10 lands in the exponent field: the smallest normal.
        result_next = {16'b0, stage_b.sign, 4'b0, sum};
      end
      KIND_NARROW_NORM: begin
        if (sum[10]) begin
          if (hexp == HALF_EXP_TOP) begin
            result_next = {16'b0, {stage_b.sign, 15'b0} | HALF_INF_BITS};
          end else begin
            result_next = {16'b0, stage_b.sign, hexp + 5'd1, 10'b0};
          end
        end else begin
          result_next = {16'b0, stage_b.sign, hexp, sum[9:0]};
        end
      end
      default: begin
        result_next = stage_b.direct;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    result_bits <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_b.valid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/half_single_float_converter_core.sv @@
// Top level of the IEEE half/single precision converter pipeline.
`default_nettype none

// Converts one operand per item between IEEE binary16 and binary32.
// An item is issued by raising start with mode and operand_bits valid; it is
// taken at the rising edge where start is high and busy is low. The pipeline
// never holds off, so busy is always low and an item may be issued every cycle.
// mode 0 widens the low 16 bits of operand_bits to single precision; mode 1
// narrows the full word to half precision with round to nearest even, and the
// upper 16 result bits are then zero.
// An item passes through the three register stages (classify, align/round
// decision, pack) and shows its result with done high from the pack register.
// Throughput is one item per cycle, as every stage advances in every cycle.
// Each result is shown for one cycle only and is not held; the receiver must
// take it then, since it has no way to stall the pipeline.
// Reset clears the valid bits of every stage, so items in flight are dropped
// and done stays low until new items come out. The block keeps no other state.
module half_single_float_converter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        mode,
  input  wire logic [31:0] operand_bits,
  output logic             busy,
  output logic             done,
  output logic [31:0]      result_bits
);
  import hsfc_pkg::*;

  stage_a_t stage_a;
  stage_b_t stage_b;
  logic     accept;

  // Every stage advances each cycle, so there is never back-pressure.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1 decodes the operand; special values, zeros and plain widening
  // are finished here and ride along as a ready-made word.
  hsfc_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (accept),
    .mode         (mode),
    .operand_bits (operand_bits),
    .stage_a      (stage_a)
  );

  // Stage 2 normalizes half subnormals and decides the rounding increment.
  hsfc_align u_align (
    .clk     (clk),
    .rst     (rst),
    .stage_a (stage_a),
    .stage_b (stage_b)
  );

  // Stage 3 adds the increment, handles mantissa carry and overflow, and
  // drives the registered result.
  hsfc_pack u_pack (
    .clk         (clk),
    .rst         (rst),
    .stage_b     (stage_b),
    .done        (done),
    .result_bits (result_bits)
  );

  // A result comes out only for an item that passed through the pipeline.
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without an item three cycles earlier");

  // Narrowed results leave the upper half of the word clear.
  a_narrow_upper_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(mode, 3)) |-> (result_bits[31:16] == 16'd0))
    else $error("narrowed result has upper bits set");

  // The sign always survives conversion in either direction.
  a_sign_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(mode, 3) ? (result_bits[15] == $past(operand_bits[31], 3))
                             : (result_bits[31] == $past(operand_bits[15], 3))))
    else $error("sign lost in conversion");

  // A single NaN narrows to a quiet half NaN.
  a_nan_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && $past(mode, 3) && ($past(operand_bits[30:23], 3) == 8'hFF) &&
     ($past(operand_bits[22:0], 3) != 23'd0)) |-> (result_bits[14:9] == 6'b111111))
    else $error("NaN did not narrow to a quiet NaN");

endmodule

`default_nettype wire
